/* src/ppat_pkg.sv */
// ----------------------------------------------------------------------------
// ppat_pkg
// shared types and constants for the polyline position block
// ----------------------------------------------------------------------------
package ppat_pkg;

  localparam int unsigned MaxVerticesDefault = 16;
  localparam int unsigned CoordW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic [15:0] SpeedReset = 16'd256;

  localparam logic [1:0] CmdClear  = 2'd0;
  localparam logic [1:0] CmdAppend = 2'd1;
  localparam logic [1:0] CmdQuery  = 2'd2;
  localparam logic [1:0] CmdNone   = 2'd3;

  localparam logic [1:0] StatOnPath = 2'd0;
  localparam logic [1:0] StatPastEnd = 2'd1;
  localparam logic [1:0] StatEmpty = 2'd2;

  localparam logic [CfgIdxW-1:0] RegSpeed    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOriginX  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOriginY  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOriginT  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBackward = 3'd4;

endpackage

/* src/polyline_position_at_time_top.sv */
// ----------------------------------------------------------------------------
// polyline_position_at_time_top
// constant-speed position along a polyline of stored waypoints
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one item per handshake: tuser = cmd, tdata = point_x,
//   point_y, now_time. clear and append leave the block idle and give no
//   result. a query gives one m_axis item: pos_x, pos_y in tdata and
//   path_status in tuser.
//   an empty list answers a query in the cycle after acceptance. each leg
//   of a query takes a read, a squaring, a 35-step square root and a
//   compare; a query that ends on a leg adds two 64-step divisions on one
//   shared restoring unit, and one that runs out of legs reports past end.
//   s_axis_tready is low while an item is worked on and while a result
//   waits; a stalled receiver holds the block with the result unchanged.
//   reset empties the waypoint list, clears the held position and loads the
//   register defaults (speed 256, 1/256 in Q0.16). waypoint memory is not cleared.
//   configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
module polyline_position_at_time_top
  import ppat_pkg::*;
#(
  parameter int unsigned MaxVertices = MaxVerticesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // point_x [31:0], point_y [63:32], now_time [95:64]
  input  logic [95:0]         s_axis_tdata,
  // cmd [1:0]
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // pos_x [31:0], pos_y [63:32]
  output logic [63:0]         m_axis_tdata,
  // path_status [1:0]
  output logic [1:0]          m_axis_tuser
);

  localparam int unsigned AddrW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int unsigned CntW = $clog2(MaxVertices + 1);

  typedef enum logic [3:0] {
    StIdle, StDist, StRead, StSq, StSqrt, StCmp, StDivX, StDivY, StOut
  } state_e;

  state_e state_q;
  logic [15:0] speed_q;
  logic signed [31:0] org_x_q, org_y_q;
  logic [31:0] org_t_q;
  logic back_q;

  logic [31:0] mem_x [MaxVertices];
  logic [31:0] mem_y [MaxVertices];
  logic [31:0] rd_x_q, rd_y_q;
  logic [CntW-1:0] cnt_q, k_q;
  logic [31:0] held_x_q, held_y_q;
  logic [1:0] stat_q;
  logic [31:0] now_q;

  logic signed [32:0] ax_q, ay_q, bx_q, by_q;
  logic [32:0] ux_q, uy_q;
  logic [63:0] rem_q;
  logic [66:0] ssq_q;
  logic [34:0] len_q;
  logic [1:0] step_q;

  // shared shift-subtract unit
  logic [127:0] num_q;
  logic [68:0] part_q;
  logic [63:0] quo_q;
  logic [6:0] it_q;

  logic [AddrW-1:0] rd_addr;
  logic [CntW-1:0] idx_c;
  always_comb begin
    idx_c = back_q ? (cnt_q - CntW'(1) - k_q) : k_q;
    rd_addr = idx_c[AddrW-1:0];
  end

  assign s_axis_tready = (state_q == StIdle);
  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser == CmdAppend && cnt_q < CntW'(MaxVertices)) begin
      mem_x[cnt_q[AddrW-1:0]] <= s_axis_tdata[31:0];
      mem_y[cnt_q[AddrW-1:0]] <= s_axis_tdata[63:32];
    end
    rd_x_q <= mem_x[rd_addr];
    rd_y_q <= mem_y[rd_addr];
  end

  // sqrt trial: (root | bit)^2 compared via restoring digit method
  logic [68:0] sq_trial;
  logic [127:0] num_sh;
  logic [64:0] div_trial;
  logic [63:0] el_c;
  always_comb begin
    sq_trial = {part_q[66:0], num_q[127:126]} - {quo_q[32:0], 2'b01};
    num_sh = num_q << 1;
    div_trial = {part_q[63:0], num_q[127]} - {30'd0, len_q};
    el_c = (now_q > org_t_q) ? 64'(now_q - org_t_q) : 64'd0;
  end

  // one squarer and one scaling multiplier, each shared across steps
  logic [32:0] sq_op;
  logic [66:0] sq_c;
  logic [63:0] prod_c;
  logic [32:0] mag_c;
  assign sq_op = (step_q == 2'd0) ? ux_q : uy_q;
  assign sq_c = 67'(sq_op) * 67'(sq_op);
  assign mag_c = (state_q == StCmp) ? ux_q : uy_q;
  assign prod_c = 64'(mag_c) * 64'(rem_q[31:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      speed_q <= SpeedReset;
      org_x_q <= '0;
      org_y_q <= '0;
      org_t_q <= '0;
      back_q <= 1'b0;
      cnt_q <= '0;
      held_x_q <= '0;
      held_y_q <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegSpeed:    speed_q <= cfg_data_i[15:0];
          RegOriginX:  org_x_q <= cfg_data_i;
          RegOriginY:  org_y_q <= cfg_data_i;
          RegOriginT:  org_t_q <= cfg_data_i;
          RegBackward: back_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            now_q <= s_axis_tdata[95:64];
            case (s_axis_tuser)
              CmdClear: cnt_q <= '0;
              CmdAppend: if (cnt_q < CntW'(MaxVertices)) cnt_q <= cnt_q + CntW'(1);
              CmdQuery: begin
                if (cnt_q == '0) begin
                  stat_q <= StatEmpty;
                  m_axis_tvalid <= 1'b1;
                  state_q <= StOut;
                end else begin
                  state_q <= StDist;
                  step_q <= '0;
                  rem_q <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        StDist: begin
          // elapsed * speed, one 8-bit speed slice per step
          case (step_q)
            2'd0: rem_q <= el_c * 64'(speed_q[7:0]);
            default: begin
              rem_q <= (rem_q + ((el_c * 64'(speed_q[15:8])) << 8)) >> 16;
              k_q <= '0;
              ax_q <= 33'(org_x_q);
              ay_q <= 33'(org_y_q);
              state_q <= StRead;
            end
          endcase
          step_q <= step_q + 2'd1;
        end
        StRead: begin
          if (k_q == cnt_q) begin
            stat_q <= StatPastEnd;
            m_axis_tvalid <= 1'b1;
            state_q <= StOut;
          end else if (step_q == 2'd1) begin
            bx_q <= 33'(signed'(rd_x_q));
            by_q <= 33'(signed'(rd_y_q));
            ux_q <= (33'(signed'(rd_x_q)) >= ax_q) ? 33'(33'(signed'(rd_x_q)) - ax_q)
                                                  : 33'(ax_q - 33'(signed'(rd_x_q)));
            uy_q <= (33'(signed'(rd_y_q)) >= ay_q) ? 33'(33'(signed'(rd_y_q)) - ay_q)
                                                  : 33'(ay_q - 33'(signed'(rd_y_q)));
            step_q <= '0;
            state_q <= StSq;
          end else begin
            step_q <= 2'd1;
          end
        end
        StSq: begin
          if (step_q == 2'd0) begin
            ssq_q <= sq_c;
            step_q <= 2'd1;
          end else begin
            ssq_q <= ssq_q + sq_c;
            num_q <= {61'd0, ssq_q + sq_c} << 58;
            part_q <= '0;
            quo_q <= '0;
            it_q <= 7'd35;
            state_q <= StSqrt;
          end
        end
        StSqrt: begin
          num_q <= num_q << 2;
          if (!sq_trial[68]) begin
            part_q <= sq_trial;
            quo_q <= {quo_q[62:0], 1'b1};
          end else begin
            part_q <= {part_q[66:0], num_q[127:126]};
            quo_q <= {quo_q[62:0], 1'b0};
          end
          it_q <= it_q - 7'd1;
          if (it_q == 7'd1) state_q <= StCmp;
        end
        StCmp: begin
          len_q <= quo_q[34:0];
          if (64'(quo_q[34:0]) > rem_q) begin
            num_q <= {prod_c, 64'd0};
            part_q <= '0;
            it_q <= 7'd64;
            state_q <= StDivX;
          end else begin
            rem_q <= rem_q - 64'(quo_q[34:0]);
            ax_q <= bx_q;
            ay_q <= by_q;
            k_q <= k_q + CntW'(1);
            step_q <= '0;
            state_q <= StRead;
          end
        end
        StDivX, StDivY: begin
          if (it_q == 7'd1 && state_q == StDivX) begin
            held_x_q <= (bx_q >= ax_q)
              ? 32'(ax_q + 33'({quo_q[62:0], !div_trial[64]}))
              : 32'(ax_q - 33'({quo_q[62:0], !div_trial[64]}));
            num_q <= {prod_c, 64'd0};
            part_q <= '0;
            it_q <= 7'd64;
            state_q <= StDivY;
          end else begin
            num_q <= num_sh;
            if (!div_trial[64]) begin
              part_q <= {4'd0, div_trial};
              quo_q <= {quo_q[62:0], 1'b1};
            end else begin
              part_q <= {4'd0, part_q[63:0], num_q[127]};
              quo_q <= {quo_q[62:0], 1'b0};
            end
            it_q <= it_q - 7'd1;
            if (it_q == 7'd1) begin
              held_y_q <= (by_q >= ay_q)
                ? 32'(ay_q + 33'({quo_q[62:0], !div_trial[64]}))
                : 32'(ay_q - 33'({quo_q[62:0], !div_trial[64]}));
              stat_q <= StatOnPath;
              m_axis_tvalid <= 1'b1;
              state_q <= StOut;
            end
          end
        end
        StOut: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tdata = {held_y_q, held_x_q};
  assign m_axis_tuser = stat_q;

endmodule

/* src/ppat_checker.sv */
// ----------------------------------------------------------------------------
// ppat_checker
// port-level checks for the polyline position block
// ----------------------------------------------------------------------------
module ppat_checker
  import ppat_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [1:0] s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [1:0] m_axis_tuser
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
    else $error("result changed under stall");

  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= StatEmpty)
    else $error("bad status");

  a_non_query_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != CmdQuery |=> !m_axis_tvalid)
    else $error("result for non-query item");

endmodule

bind polyline_position_at_time_top ppat_checker u_ppat_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tuser,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tuser
);

/* tb/tb_polyline_position_at_time_top.sv */
// ----------------------------------------------------------------------------
// tb_polyline_position_at_time_top
// self-checking bench for the polyline position block: clear, append and
// query items with random gaps and receiver stalls, checked against an
// internal fixed-point predictor of the walk along the waypoint legs
// ----------------------------------------------------------------------------
module tb_polyline_position_at_time_top;
  import ppat_pkg::*;

  localparam int unsigned NumVerts = 16;
  localparam int unsigned IdleLimit = 40000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now_time;
    logic [31:0] point_y;
    logic [31:0] point_x;
  } path_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } pos_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [95:0]         s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [63:0]         m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  polyline_position_at_time_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // predictor state
  logic [15:0] spd_q;
  logic [31:0] org_x_q, org_y_q, org_t_q;
  logic        backward_q;
  logic [31:0] wp_x[NumVerts];
  logic [31:0] wp_y[NumVerts];
  int unsigned wp_cnt;
  logic [31:0] hold_x, hold_y;

  path_item_t  pending_items[$];
  pos_result_t expected_pos[$];
  int unsigned n_fail;
  int unsigned idle_cycles;
  int unsigned stall_hold;
  bit          running;
  bit          took_q;

  function automatic logic [63:0] leg_length(logic [33:0] dx, logic [33:0] dy);
    logic [71:0] sq;
    logic [71:0] cand;
    logic [34:0] root;
    root = '0;
    sq = 72'(dx) * 72'(dx) + 72'(dy) * 72'(dy);
    for (int b = 34; b >= 0; b--) begin
      cand = 72'(root | (35'd1 << b));
      if (cand * cand <= sq) root = root | (35'd1 << b);
    end
    return 64'(root);
  endfunction

  function automatic logic signed [33:0] lerp_axis(logic signed [33:0] a,
      logic signed [33:0] b, logic [63:0] trav, logic [63:0] len);
    logic [127:0] step;
    if (a == b) return a;
    if (b > a) begin
      step = (128'(b - a) * 128'(trav)) / 128'(len);
      return a + 34'(step);
    end
    step = (128'(a - b) * 128'(trav)) / 128'(len);
    return a - 34'(step);
  endfunction

  task automatic predict_item(input path_item_t it);
    logic [63:0] trav, len;
    logic [31:0] elapsed;
    logic signed [33:0] ax, ay, bx, by;
    logic [33:0] ux, uy;
    logic [1:0] status;
    int unsigned idx;
    pos_result_t r;
    if (it.cmd == CmdClear) begin
      wp_cnt = 0;
    end else if (it.cmd == CmdAppend) begin
      if (wp_cnt < NumVerts) begin
        wp_x[wp_cnt] = it.point_x;
        wp_y[wp_cnt] = it.point_y;
        wp_cnt++;
      end
    end else if (it.cmd == CmdQuery) begin
      status = StatPastEnd;
      if (wp_cnt == 0) begin
        status = StatEmpty;
      end else begin
        elapsed = (it.now_time > org_t_q) ? it.now_time - org_t_q : 32'd0;
        trav = (64'(elapsed) * 64'(spd_q)) >> 16;
        ax = 34'(signed'(org_x_q));
        ay = 34'(signed'(org_y_q));
        for (int k = 0; k < wp_cnt; k++) begin
          idx = backward_q ? wp_cnt - 1 - k : k;
          bx = 34'(signed'(wp_x[idx]));
          by = 34'(signed'(wp_y[idx]));
          ux = (bx >= ax) ? bx - ax : ax - bx;
          uy = (by >= ay) ? by - ay : ay - by;
          len = leg_length(ux, uy);
          if (len > trav) begin
            hold_x = 32'(lerp_axis(ax, bx, trav, len));
            hold_y = 32'(lerp_axis(ay, by, trav, len));
            status = StatOnPath;
            break;
          end
          trav = trav - len;
          ax = bx;
          ay = by;
        end
      end
      r.pos_x = hold_x;
      r.pos_y = hold_y;
      r.status = status;
      expected_pos.push_back(r);
    end
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return $urandom();
      default: return 32'($signed($urandom_range(0, 8000)) - 4000);
    endcase
  endfunction

  task automatic add_item(input logic [1:0] cmd, input logic [31:0] px,
      input logic [31:0] py, input logic [31:0] t);
    path_item_t it;
    it.cmd = cmd;
    it.point_x = px;
    it.point_y = py;
    it.now_time = t;
    pending_items.push_back(it);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegSpeed:    spd_q = val[15:0];
      RegOriginX:  org_x_q = val;
      RegOriginY:  org_y_q = val;
      RegOriginT:  org_t_q = val;
      RegBackward: backward_q = val[0];
      default: ;
    endcase
  endtask

  task automatic drain_all();
    while (pending_items.size() != 0 || expected_pos.size() != 0) @(posedge clk_i);
    repeat (3500) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // driver: bursts and gaps
  int unsigned burst_left, gap_left;
  always @(negedge clk_i) begin
    if (s_axis_tvalid && !took_q) begin
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      s_axis_tvalid <= 1'b0;
    end else if (pending_items.size() != 0) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tuser <= pending_items[0].cmd;
      s_axis_tdata <= {pending_items[0].now_time, pending_items[0].point_y,
                       pending_items[0].point_x};
      if (burst_left == 0) begin
        burst_left <= $urandom_range(1, 8);
        if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 30);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: m_axis_tready <= 1'b0;
        2: begin
          m_axis_tready <= 1'b0;
          stall_hold <= $urandom_range(5, 600);
        end
        default: m_axis_tready <= 1'b1;
      endcase
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    pos_result_t want;
    took_q <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && running) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_item(pending_items.pop_front());
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pos.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("unexpected result x=%h y=%h st=%0d",
              m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
        end else begin
          want = expected_pos.pop_front();
          if (m_axis_tdata[31:0] !== want.pos_x || m_axis_tdata[63:32] !== want.pos_y
              || m_axis_tuser !== want.status) begin
            n_fail++;
            if (n_fail <= 10) $display("mismatch exp x=%h y=%h st=%0d act x=%h y=%h st=%0d",
                want.pos_x, want.pos_y, want.status, m_axis_tdata[31:0],
                m_axis_tdata[63:32], m_axis_tuser);
          end
        end
      end
      if (idle_cycles > IdleLimit) begin
        $display("polyline_position_at_time_top verification failed");
        $finish;
      end
    end
  end

  task automatic random_path(input int unsigned n_items);
    int unsigned done;
    int unsigned legs;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        add_item(2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom());
        done++;
        continue;
      end
      add_item(CmdClear, $urandom(), $urandom(), $urandom());
      legs = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 5);
      for (int i = 0; i < legs; i++) add_item(CmdAppend, rand_coord(), rand_coord(), $urandom());
      done += legs + 1;
      for (int q = 0; q < $urandom_range(1, 4); q++) begin
        add_item(CmdQuery, $urandom(), $urandom(),
                 ($urandom_range(0, 3) == 0) ? $urandom() : org_t_q + $urandom_range(0, 2000000));
        done++;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CmdClear;
    m_axis_tready = 1'b0;
    burst_left = 0;
    gap_left = 0;
    stall_hold = 0;
    n_fail = 0;
    idle_cycles = 0;
    running = 0;
    took_q = 0;
    spd_q = SpeedReset;
    org_x_q = '0;
    org_y_q = '0;
    org_t_q = '0;
    backward_q = 1'b0;
    wp_cnt = 0;
    hold_x = '0;
    hold_y = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    running = 1;

    // directed: empty path, extremes, overflow, clamp, backward, unused command
    add_item(CmdQuery, '0, '0, 32'hffff_ffff);
    add_item(CmdNone, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    add_item(CmdAppend, 32'h0000_1000, 32'h0000_0000, '0);
    add_item(CmdAppend, 32'h0000_1000, 32'h0000_1000, '0);
    add_item(CmdAppend, 32'h0000_1000, 32'h0000_1000, '0);
    add_item(CmdQuery, '0, '0, 32'h0000_0000);
    add_item(CmdQuery, '0, '0, 32'h0008_0000);
    add_item(CmdQuery, '0, '0, 32'h0018_0000);
    add_item(CmdQuery, '0, '0, 32'hffff_ffff);
    add_item(CmdClear, '0, '0, '0);
    add_item(CmdQuery, '0, '0, 32'h0001_0000);
    for (int i = 0; i < 17; i++)
      add_item(CmdAppend, (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff,
               (i % 3) ? 32'h7fff_ffff : 32'h8000_0000, '0);
    add_item(CmdQuery, '0, '0, 32'h0100_0000);
    drain_all();

    write_reg(RegSpeed, 32'h0000_ffff);
    write_reg(RegOriginX, 32'h8000_0000);
    write_reg(RegOriginY, 32'h7fff_ffff);
    write_reg(RegOriginT, 32'h0010_0000);
    write_reg(RegBackward, 32'd1);
    add_item(CmdQuery, '0, '0, 32'h0000_0000);
    add_item(CmdQuery, '0, '0, 32'hffff_ffff);
    random_path(200);
    drain_all();

    // long receiver hold-off while the sender keeps offering
    write_reg(RegSpeed, 32'd0);
    write_reg(RegBackward, 32'd0);
    write_reg(RegOriginX, 32'd0);
    write_reg(RegOriginY, 32'd0);
    @(negedge clk_i);
    stall_hold = 3000;
    random_path(150);
    drain_all();

    write_reg(RegSpeed, 32'h0000_0400);
    write_reg(RegOriginT, 32'h0000_0000);
    random_path(300);
    drain_all();

    write_reg(RegSpeed, 32'h0000_0100);
    write_reg(RegOriginX, 32'hffff_f000);
    write_reg(RegOriginY, 32'h0000_0800);
    write_reg(RegOriginT, 32'hffff_0000);
    write_reg(RegBackward, 32'd1);
    random_path(300);
    drain_all();

    if (n_fail == 0) begin
      $display("polyline_position_at_time_top verification clean");
    end else begin
      $display("polyline_position_at_time_top verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/ppat_pkg.sv
src/polyline_position_at_time_top.sv
src/ppat_checker.sv
tb/tb_polyline_position_at_time_top.sv
